/* rtl/bdf_pkg.sv */
// shared types, codes and saturation helper for the direct form ii biquad
// no dependencies
package bdf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 31;
  localparam int unsigned ProdW  = 2 * DataW;
  localparam int unsigned FracW  = 15;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegFeedB0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFeedB1     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFeedB2     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBackA1     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackA2     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMakeupGain = 3'd5;

  localparam logic [GainW-1:0] GainReset = 31'd32768;

  typedef enum logic [2:0] {
    MUL_A1W1,
    MUL_A2W2,
    MUL_B0W0,
    MUL_B1W1,
    MUL_B2W2,
    MUL_YG
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef struct packed {
    logic     x_ld;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     w0_ld;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  // clamp a wide signed value into the 32-bit signed range
  function automatic logic signed [DataW-1:0] sat_w(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] max_v;
    logic signed [ProdW-1:0] min_v;
    max_v = {{(ProdW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    min_v = {{(ProdW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
    if (v > max_v) begin
      sat_w = max_v[DataW-1:0];
    end else if (v < min_v) begin
      sat_w = min_v[DataW-1:0];
    end else begin
      sat_w = v[DataW-1:0];
    end
  endfunction

endpackage

/* rtl/bdf_dp.sv */
// datapath: coefficient registers, delay words, shared multiplier, accumulator
// and output register; depends on bdf_pkg
module bdf_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdf_pkg::DataW-1:0]      cfg_data_i,
  input  logic [bdf_pkg::DataW-1:0]      in_data_i,
  input  bdf_pkg::dp_cmd_t               cmd_i,
  output bdf_pkg::dp_sts_t               sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bdf_pkg::DataW-1:0]      out_data_o
);
  import bdf_pkg::*;

  logic signed [DataW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic        [GainW-1:0] gain_q;
  logic signed [DataW-1:0] x_q, w0_q, w1_q, w2_q, acc_q, out_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [DataW-1:0] op_a, op_b;
  logic signed [DataW-1:0] psat;
  logic signed [DataW-1:0] acc_d;
  logic signed [DataW-1:0] w0_d;
  logic                    out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= '0;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFeedB0:     b0_q   <= cfg_data_i;
        RegFeedB1:     b1_q   <= cfg_data_i;
        RegFeedB2:     b2_q   <= cfg_data_i;
        RegBackA1:     a1_q   <= cfg_data_i;
        RegBackA2:     a2_q   <= cfg_data_i;
        RegMakeupGain: gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_A1W1: begin op_a = a1_q;  op_b = w1_q; end
      MUL_A2W2: begin op_a = a2_q;  op_b = w2_q; end
      MUL_B0W0: begin op_a = b0_q;  op_b = w0_q; end
      MUL_B1W1: begin op_a = b1_q;  op_b = w1_q; end
      MUL_B2W2: begin op_a = b2_q;  op_b = w2_q; end
      MUL_YG:   begin op_a = acc_q; op_b = {1'b0, gain_q}; end
      default:  begin op_a = '0;    op_b = '0; end
    endcase
  end

  assign prod_d = ProdW'(op_a) * ProdW'(op_b);

  // arithmetic shift floors, then clamp
  assign psat = sat_w(prod_q >>> FracW);
  assign w0_d = sat_w(ProdW'(x_q) - ProdW'(acc_q));

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD: acc_d = psat;
      ACC_ADD:  acc_d = sat_w(ProdW'(acc_q) + ProdW'(psat));
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.x_ld)   x_q    <= in_data_i;
    if (cmd_i.mul_en) prod_q <= prod_d;
    acc_q <= acc_d;
    if (cmd_i.w0_ld)  w0_q   <= w0_d;
    if (cmd_i.out_ld) out_q  <= psat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q        <= '0;
      w2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_ld) begin
        w2_q <= w1_q;
        w1_q <= w0_q;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |=> out_valid_q && out_q == $past(psat))
    else $error("output word not loaded");

  a_delay_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |=> w2_q == $past(w1_q) && w1_q == $past(w0_q))
    else $error("delay words not shifted on completion");

  a_valid_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("output word dropped without acceptance");

endmodule

/* rtl/bdf_ctrl.sv */
// controller: sequences the shared multiplier through the filter steps
// depends on bdf_pkg
module bdf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdf_pkg::dp_sts_t  sts_i,
  output bdf_pkg::dp_cmd_t  cmd_o
);
  import bdf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_A1   = 11'b000_0000_0010,
    S_A2   = 11'b000_0000_0100,
    S_FB   = 11'b000_0000_1000,
    S_W0   = 11'b000_0001_0000,
    S_B0   = 11'b000_0010_0000,
    S_B1   = 11'b000_0100_0000,
    S_B2   = 11'b000_1000_0000,
    S_Y    = 11'b001_0000_0000,
    S_G    = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_A1W1;
    cmd_o.acc_op   = ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.x_ld = in_acc;
        if (in_acc) state_d = S_A1;
      end
      S_A1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A1W1;
        state_d       = S_A2;
      end
      S_A2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A2W2;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = S_FB;
      end
      S_FB: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_W0;
      end
      S_W0: begin
        cmd_o.w0_ld = 1'b1;
        state_d     = S_B0;
      end
      S_B0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B0W0;
        state_d       = S_B1;
      end
      S_B1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B1W1;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = S_B2;
      end
      S_B2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B2W2;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = S_Y;
      end
      S_Y: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = S_G;
      end
      S_G: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_YG;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous word is still unclaimed
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_A1)
    else $error("accepted word did not start the sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !sts_i.out_busy)
    else $error("output register overwritten while held");

  a_feedback_before_w0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.w0_ld |-> $past(cmd_o.acc_op == ACC_ADD) && $past(cmd_o.mul_sel == MUL_A2W2, 2))
    else $error("w0 formed before feedback sum finished");

endmodule

/* rtl/biquad_direct_form_two.sv */
// top level of the q16.15 direct form ii biquad filter
// depends on bdf_pkg, bdf_ctrl and bdf_dp
//
//  port group   dir  payload
//  s_axis       in   tdata[31:0] = sample_in
//  m_axis       out  tdata[31:0] = filtered_out
//  cfg          in   idx 0..5 = b0, b1, b2, a1, a2, makeup gain
//
// from acceptance to the output register, the six products of one word all go
// through one 32x32 multiplier in series, w0 waits on both feedback products,
// and the gain multiply waits on the full feedforward sum.
// the next word is accepted on the cycle after the result is loaded.
// reset clears the delay words, sets coefficients to zero and gain to one.
// a result not taken holds the next word in its last step until m_axis_tready.
module biquad_direct_form_two (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bdf_pkg::DataW-1:0]   s_axis_tdata_i,   // [31:0] sample_in
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bdf_pkg::DataW-1:0]   m_axis_tdata_o,   // [31:0] filtered_out
  input  logic                        cfg_we_i,
  input  logic [bdf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdf_pkg::DataW-1:0]   cfg_data_i
);
  import bdf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

/* verif/tb_biquad_direct_form_two.sv */
`timescale 1ns / 100ps
// self-checking testbench for the q16.15 direct form ii biquad filter
// depends on bdf_pkg and biquad_direct_form_two; predicts every output word
module tb_biquad_direct_form_two;
  import bdf_pkg::*;

  typedef logic signed [DataW-1:0] q15_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam q15_t QOne = 32'sd32768;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned LongStall = 300;
  localparam int unsigned DrainCycles = 20;
  // indexes past the register list, writes there must not land anywhere
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  q15_t s_data = '0;
  logic m_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [DataW-1:0] cfg_data = '0;
  logic s_ready;
  logic m_valid;
  logic [DataW-1:0] m_data;

  // filter settings and delay line as the block should hold them
  q15_t coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [GainW-1:0] gain_q15;
  q15_t w1_state, w2_state;

  q15_t sample_q[$];
  q15_t filtered_q[$];
  int unsigned gap_pct = 6;
  int unsigned mismatches = 0;
  int unsigned words_out = 0;
  int unsigned stall_left = 0;
  logic stall_done = 1'b0;
  int unsigned idle_cycles = 0;

  biquad_direct_form_two u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),    // [31:0] sample_in
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),    // [31:0] filtered_out
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  function automatic q15_t clamp32(input longint v);
    if (v > QMax) begin
      return q15_t'(QMax);
    end else if (v < QMin) begin
      return q15_t'(QMin);
    end
    return q15_t'(v);
  endfunction

  // full 64-bit product, arithmetic shift rounds toward minus infinity
  function automatic q15_t q15_mul(input q15_t a, input q15_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FracW);
  endfunction

  function automatic q15_t q15_add(input q15_t a, input q15_t b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic q15_t q15_sub(input q15_t a, input q15_t b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  task automatic filter_sample(input q15_t x);
    q15_t fb, w0, y;
    fb = q15_add(q15_mul(coef_a1, w1_state), q15_mul(coef_a2, w2_state));
    w0 = q15_sub(x, fb);
    y = q15_add(q15_add(q15_mul(coef_b0, w0), q15_mul(coef_b1, w1_state)),
                q15_mul(coef_b2, w2_state));
    filtered_q.insert(filtered_q.size(), q15_mul(y, q15_t'({1'b0, gain_q15})));
    w2_state = w1_state;
    w1_state = w0;
  endtask

  function automatic q15_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return q15_t'($urandom);
    end else if (sel < 9) begin
      return q15_t'(int'($urandom_range(1 << 18)) - (1 << 17));
    end
    return $urandom_range(1) ? q15_t'(QMax) : q15_t'(QMin);
  endfunction

  function automatic q15_t pick_coef(input int span);
    return q15_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  // sender: holds a word until taken, idles at random between words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
    end else begin
      if (s_valid && s_ready) begin
        filter_sample(s_data);
      end
      if (!s_valid || s_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          s_valid <= 1'b1;
          s_data <= sample_q.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        words_out <= words_out + 1;
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %0d (%h)",
                   $time, $signed(m_data), m_data);
          mismatches <= mismatches + 1;
        end else begin
          if (m_data !== filtered_q[0]) begin
            $display("%0t: filtered_out mismatch, expected %0d (%h), actual %0d (%h)",
                     $time, filtered_q[0], filtered_q[0], $signed(m_data), m_data);
            mismatches <= mismatches + 1;
          end
          void'(filtered_q.pop_front());
        end
      end
      // one long hold-off once the sender has a backlog, so the input stalls
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_ready <= 1'b0;
      end else if (!stall_done && words_out >= 150 && sample_q.size() >= 10) begin
        stall_done <= 1'b1;
        stall_left <= LongStall;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      RegFeedB0: coef_b0 = q15_t'(data);
      RegFeedB1: coef_b1 = q15_t'(data);
      RegFeedB2: coef_b2 = q15_t'(data);
      RegBackA1: coef_a1 = q15_t'(data);
      RegBackA2: coef_a2 = q15_t'(data);
      RegMakeupGain: gain_q15 = data[GainW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_coefs(input q15_t b0, input q15_t b1, input q15_t b2,
                            input q15_t a1, input q15_t a2, input logic [DataW-1:0] gain);
    write_reg(RegFeedB0, b0);
    write_reg(RegFeedB1, b1);
    write_reg(RegFeedB2, b2);
    write_reg(RegBackA1, a1);
    write_reg(RegBackA2, a2);
    write_reg(RegMakeupGain, gain);
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_valid || filtered_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    coef_b0 = '0;
    coef_b1 = '0;
    coef_b2 = '0;
    coef_a1 = '0;
    coef_a2 = '0;
    gain_q15 = GainReset;
    w1_state = '0;
    w2_state = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: all coefficients zero, output stays zero
    sample_q = '{q15_t'(QMax), q15_t'(QMin), q15_t'(-1), 32'sd1};
    wait_drained();

    // straight pass-through
    load_coefs(QOne, '0, '0, '0, '0, GainReset);
    sample_q = '{q15_t'(QMax), q15_t'(QMin), '0, q15_t'(-1), 32'sd1, QOne, -QOne,
                 q15_t'(32'h5555_5555), q15_t'(32'hAAAA_AAAA)};
    wait_drained();

    // extreme coefficients can saturate the steps; top gain bit must be dropped
    load_coefs(q15_t'(QMax), q15_t'(QMin), q15_t'(QMax), q15_t'(QMin), q15_t'(QMax),
               32'hFFFF_FFFF);
    write_reg(RegSpareLo, 32'h5A5A_5A5A);
    write_reg(RegSpareHi, 32'hA5A5_A5A5);
    sample_q = '{32'sd1, q15_t'(QMax), q15_t'(QMin), '0, q15_t'(-1), q15_t'(QMax),
                 -QOne, q15_t'(QMin)};
    wait_drained();

    // zero gain silences the output while the delay line still runs
    load_coefs(32'sd16384, 32'sd8192, -32'sd4096, 32'sd12000, -32'sd9000, '0);
    sample_q = '{q15_t'(QMax), q15_t'(QMin), 32'sd70000};
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) begin
        load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        load_coefs(pick_coef(65536), pick_coef(65536), pick_coef(65536),
                   pick_coef(49152), pick_coef(29491),
                   (ph == 5) ? 32'h7FFF_FFFF : $urandom_range(4 * 32768));
      end
      gap_pct = (ph == 1) ? 0 : 6;
      for (int k = 0; k < 32; k++) sample_q.insert(sample_q.size(), pick_sample());
      // sender pauses mid-setting until every output has come back
      wait_drained();
      for (int k = 0; k < 32; k++) sample_q.insert(sample_q.size(), pick_sample());
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
